// File: design/hsl_to_rgb_converter_assert.svh
// Assertion macros for the HSL to RGB converter checker.
// Included by files that carry concurrent assertions; no dependencies.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define HSL2RGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define HSL2RGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/hsl2rgb_pkg.sv
// Package for the HSL to RGB converter: fixed-point widths, constants,
// hue sector codes and the input rescale function. No dependencies.
package hsl2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 17;
    localparam int IN_FRAC   = 16;
    localparam int BYTE_W    = 8;
    localparam int N_STAGES  = 4;

    localparam int UP_SHIFT  = (FRAC_BITS > IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int DN_SHIFT  = (IN_FRAC > FRAC_BITS) ? IN_FRAC - FRAC_BITS : 0;
    localparam int WIDE_W    = IN_W + UP_SHIFT;

    localparam int FIX_W     = FRAC_BITS + 1;
    localparam int OMT_W     = FRAC_BITS + 3;
    localparam int H6_W      = FRAC_BITS + 4;
    localparam int C_W       = FRAC_BITS + 4;
    localparam int CH_W      = FRAC_BITS + 5;
    localparam int SEC_Q_W   = H6_W - FRAC_BITS;

    localparam logic [OMT_W-1:0] ONE_OMT = OMT_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    function automatic logic [FIX_W-1:0] to_fix(input logic [IN_W-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(v) << UP_SHIFT;
        return FIX_W'(wide >> DN_SHIFT);
    endfunction

endpackage

// File: design/hsl2rgb_to_byte.sv
// Output byte conversion for one color channel: scale by 255, clamp, truncate.
// Depends on hsl2rgb_pkg.
module hsl2rgb_to_byte import hsl2rgb_pkg::*; (
    input  logic signed [CH_W-1:0]   i_chan,
    output logic        [BYTE_W-1:0] o_byte
);

    localparam int P_W = CH_W + 8;
    localparam int Q_W = P_W - FRAC_BITS;

    logic [P_W-1:0] prod;
    logic [Q_W-1:0] q;

    assign prod = {i_chan, 8'd0} - P_W'(unsigned'(i_chan));
    assign q    = prod[P_W-1:FRAC_BITS];

    always_comb begin
        if (i_chan[CH_W-1]) begin
            o_byte = '0;
        end else if (q > Q_W'(255)) begin
            o_byte = '1;
        end else begin
            o_byte = q[BYTE_W-1:0];
        end
    end

endmodule

// File: design/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: four-stage pipeline with elastic valids.
// Depends on hsl2rgb_pkg and hsl2rgb_to_byte.
//
// Converts one color per clock from hue, saturation and lightness (unsigned,
// 65536 = 1.0) to 8-bit red, green and blue. Throughput is one item per cycle
// while a low i_ready does not hold a full pipeline. The stages are: rescale and
// lightness term, chroma multiply with hue sector decode, intermediate-component
// multiply with offset, then channel select and byte conversion into the output
// register. Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up under back pressure. o_ready depends
// combinationally on i_ready through that chain.
module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_W-1:0]   i_hue,
    input  logic [IN_W-1:0]   i_saturation,
    input  logic [IN_W-1:0]   i_lightness,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_red,
    output logic [BYTE_W-1:0] o_green,
    output logic [BYTE_W-1:0] o_blue
);

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] adv;

    always_comb begin
        adv[N_STAGES-1] = !r_vld[N_STAGES-1] || i_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[N_STAGES-1];

    // stage 1: rescale, 1 - |2L - 1|, 6H
    logic        [FIX_W-1:0] h_fix, s_fix, l_fix;
    logic signed [OMT_W-1:0] n_dm;
    logic        [OMT_W-1:0] n_t;
    logic signed [OMT_W-1:0] n_omt;
    logic        [H6_W-1:0]  n_h6;

    logic signed [OMT_W-1:0] r_s1_omt;
    logic        [FIX_W-1:0] r_s1_s, r_s1_l;
    logic        [H6_W-1:0]  r_s1_h6;

    always_comb begin
        h_fix = to_fix(i_hue);
        s_fix = to_fix(i_saturation);
        l_fix = to_fix(i_lightness);
        n_dm  = $signed({1'b0, l_fix, 1'b0}) - $signed(ONE_OMT);
        n_t   = n_dm[OMT_W-1] ? unsigned'(-n_dm) : unsigned'(n_dm);
        n_omt = $signed(ONE_OMT - n_t);
        n_h6  = (H6_W'(h_fix) << 2) + (H6_W'(h_fix) << 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_omt <= n_omt;
            r_s1_s   <= s_fix;
            r_s1_l   <= l_fix;
            r_s1_h6  <= n_h6;
        end
    end

    // stage 2: chroma, sector, hue ramp
    localparam int P1_W = OMT_W + FIX_W + 1;

    logic signed [P1_W-1:0]    prod_c;
    logic signed [C_W-1:0]     n_c;
    logic        [SEC_Q_W-1:0] sec_q;
    t_sector                   n_sec;
    logic        [FIX_W-1:0]   ramp;
    logic        [FIX_W-1:0]   n_k;

    logic signed [C_W-1:0]   r_s2_c;
    logic        [FIX_W-1:0] r_s2_k, r_s2_l;
    t_sector                 r_s2_sec;

    always_comb begin
        prod_c = r_s1_omt * $signed({1'b0, r_s1_s});
        n_c    = C_W'(prod_c >>> FRAC_BITS);
        sec_q  = r_s1_h6[H6_W-1:FRAC_BITS];
        if (sec_q >= SEC_Q_W'(SEC_MAG_RED)) begin
            n_sec = SEC_MAG_RED;
        end else begin
            n_sec = t_sector'(sec_q[2:0]);
        end
        ramp = r_s1_h6[FRAC_BITS:0];
        n_k  = ramp[FRAC_BITS] ? (FIX_W'(0) - ramp) : ramp;
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_c   <= n_c;
            r_s2_k   <= n_k;
            r_s2_l   <= r_s1_l;
            r_s2_sec <= n_sec;
        end
    end

    // stage 3: intermediate component and offset
    localparam int P2_W = C_W + FIX_W + 1;

    logic signed [P2_W-1:0] prod_x;
    logic signed [C_W-1:0]  n_x;
    logic signed [CH_W-1:0] n_m;

    logic signed [C_W-1:0]  r_s3_c, r_s3_x;
    logic signed [CH_W-1:0] r_s3_m;
    t_sector                r_s3_sec;

    always_comb begin
        prod_x = r_s2_c * $signed({1'b0, r_s2_k});
        n_x    = C_W'(prod_x >>> FRAC_BITS);
        n_m    = $signed(CH_W'(r_s2_l)) - CH_W'(r_s2_c >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_c   <= r_s2_c;
            r_s3_x   <= n_x;
            r_s3_m   <= n_m;
            r_s3_sec <= r_s2_sec;
        end
    end

    // stage 4: sector select, offset add, byte conversion
    logic signed [C_W-1:0]    v_r, v_g, v_b;
    logic signed [CH_W-1:0]   ch_r, ch_g, ch_b;
    logic        [BYTE_W-1:0] n_red, n_green, n_blue;

    logic [BYTE_W-1:0] r_red, r_green, r_blue;

    always_comb begin
        unique case (r_s3_sec)
            SEC_RED_YEL: begin v_r = r_s3_c; v_g = r_s3_x; v_b = '0;     end
            SEC_YEL_GRN: begin v_r = r_s3_x; v_g = r_s3_c; v_b = '0;     end
            SEC_GRN_CYN: begin v_r = '0;     v_g = r_s3_c; v_b = r_s3_x; end
            SEC_CYN_BLU: begin v_r = '0;     v_g = r_s3_x; v_b = r_s3_c; end
            SEC_BLU_MAG: begin v_r = r_s3_x; v_g = '0;     v_b = r_s3_c; end
            SEC_MAG_RED: begin v_r = r_s3_c; v_g = '0;     v_b = r_s3_x; end
            default:     begin v_r = '0;     v_g = '0;     v_b = '0;     end
        endcase
        ch_r = CH_W'(v_r) + r_s3_m;
        ch_g = CH_W'(v_g) + r_s3_m;
        ch_b = CH_W'(v_b) + r_s3_m;
    end

    hsl2rgb_to_byte u_byte_r (.i_chan(ch_r), .o_byte(n_red));
    hsl2rgb_to_byte u_byte_g (.i_chan(ch_g), .o_byte(n_green));
    hsl2rgb_to_byte u_byte_b (.i_chan(ch_b), .o_byte(n_blue));

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// File: design/hsl2rgb_checker.sv
// Port-level checker for the HSL to RGB converter, bound to the top level.
// Depends on hsl_to_rgb_converter_assert.svh.
`include "hsl_to_rgb_converter_assert.svh"

module hsl2rgb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    logic        w_stall;
    logic [23:0] w_rgb;

    assign w_stall = o_valid && !i_ready;
    assign w_rgb   = {o_red, o_green, o_blue};

    `HSL2RGB_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
    `HSL2RGB_ASSERT(a_hold, i_clk, i_rst_n, w_stall |=> o_valid && $stable(w_rgb), "item changed")
    `HSL2RGB_ASSERT(a_empty_ready, i_clk, i_rst_n, !o_valid |-> o_ready, "stalled while empty")
    `HSL2RGB_ASSERT(a_drain_ready, i_clk, i_rst_n, i_ready |-> o_ready, "stalled while draining")

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hsl_to_rgb_converter: drives colors through the
// valid/ready input, predicts each RGB byte triple and checks it at the output.
// Depends on hsl2rgb_pkg and the hsl_to_rgb_converter RTL.
module tb_top;
    import hsl2rgb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb;

    localparam logic [IN_W-1:0] FRAC_ONE = IN_W'(65536);
    localparam logic [IN_W-1:0] FRAC_MAX = {IN_W{1'b1}};
    localparam logic [IN_W-1:0] FRAC_HALF = IN_W'(32768);

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [IN_W-1:0]   i_hue = '0;
    logic [IN_W-1:0]   i_saturation = '0;
    logic [IN_W-1:0]   i_lightness = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [BYTE_W-1:0] o_red;
    logic [BYTE_W-1:0] o_green;
    logic [BYTE_W-1:0] o_blue;

    t_rgb expected_rgb[$];
    t_rgb want_rgb;
    int   errors = 0;
    int   send_idle_pct = 0;
    int   ready_stall_pct = 0;

    hsl_to_rgb_converter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_lightness (i_lightness),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint rescale(logic [IN_W-1:0] v);
        longint w;
        w = longint'(v);
        w = w >> DN_SHIFT;
        return w << UP_SHIFT;
    endfunction

    function automatic logic [BYTE_W-1:0] channel_byte(longint level);
        longint scaled;
        longint q;
        scaled = level * 255;
        if (scaled < 0) begin
            return '0;
        end
        q = scaled >>> FRAC_BITS;
        if (q > 255) begin
            q = 255;
        end
        return BYTE_W'(q);
    endfunction

    function automatic t_rgb predict_rgb(logic [IN_W-1:0] hue, logic [IN_W-1:0] sat,
                                         logic [IN_W-1:0] lit);
        longint  one, h, s, l, t, c, h6, r, k, x, m;
        longint  rv, gv, bv, q;
        t_sector sec;
        t_rgb    res;
        one = longint'(1) <<< FRAC_BITS;
        h = rescale(hue);
        s = rescale(sat);
        l = rescale(lit);
        t = 2 * l - one;
        if (t < 0) begin
            t = -t;
        end
        c = ((one - t) * s) >>> FRAC_BITS;
        h6 = 6 * h;
        r = h6 % (2 * one);
        k = r - one;
        if (k < 0) begin
            k = -k;
        end
        k = one - k;
        x = (c * k) >>> FRAC_BITS;
        m = l - (c >>> 1);
        q = h6 / one;
        if (q > 5) begin
            q = 5;
        end
        sec = t_sector'(q);
        case (sec)
            SEC_RED_YEL: begin rv = c; gv = x; bv = 0; end
            SEC_YEL_GRN: begin rv = x; gv = c; bv = 0; end
            SEC_GRN_CYN: begin rv = 0; gv = c; bv = x; end
            SEC_CYN_BLU: begin rv = 0; gv = x; bv = c; end
            SEC_BLU_MAG: begin rv = x; gv = 0; bv = c; end
            default:     begin rv = c; gv = 0; bv = x; end
        endcase
        res.red = channel_byte(rv + m);
        res.green = channel_byte(gv + m);
        res.blue = channel_byte(bv + m);
        return res;
    endfunction

    function automatic logic [IN_W-1:0] random_fraction();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78) begin
            return IN_W'($urandom_range(0, 65536));
        end else if (pick < 88) begin
            case ($urandom_range(4))
                0: return '0;
                1: return FRAC_ONE;
                2: return FRAC_ONE - 1;
                3: return FRAC_HALF;
                default: return IN_W'(1);
            endcase
        end
        return IN_W'($urandom_range(0, 131071));
    endfunction

    function automatic logic [IN_W-1:0] random_hue();
        int k;
        if ($urandom_range(9) == 0) begin
            k = $urandom_range(1, 5);
            return IN_W'((k * 65536 + 5) / 6 - $urandom_range(0, 2) + 1);
        end
        return random_fraction();
    endfunction

    task automatic send_color(logic [IN_W-1:0] hue, logic [IN_W-1:0] sat,
                              logic [IN_W-1:0] lit);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            i_hue = IN_W'($urandom);
            i_saturation = IN_W'($urandom);
            i_lightness = IN_W'($urandom);
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_hue = hue;
        i_saturation = sat;
        i_lightness = lit;
        do @(posedge i_clk); while (!o_ready);
        expected_rgb.push_back(predict_rgb(hue, sat, lit));
        @(negedge i_clk);
    endtask

    task automatic check_channel(string name, logic [BYTE_W-1:0] exp_v,
                                 logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rgb.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %0d %0d %0d",
                         $time, o_red, o_green, o_blue);
                errors++;
            end else begin
                want_rgb = expected_rgb.pop_front();
                check_channel("red", want_rgb.red, o_red);
                check_channel("green", want_rgb.green, o_green);
                check_channel("blue", want_rgb.blue, o_blue);
            end
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        ready_stall_pct = 0;
        send_color('0, '0, '0);
        send_color('0, '0, FRAC_ONE);
        send_color('0, FRAC_ONE, FRAC_HALF);
        send_color(FRAC_ONE, FRAC_ONE, FRAC_HALF);
        send_color(FRAC_ONE - 1, FRAC_ONE, FRAC_HALF);
        for (int k = 1; k <= 5; k++) begin
            send_color(IN_W'((k * 65536 + 5) / 6), FRAC_ONE, FRAC_HALF);
            send_color(IN_W'((k * 65536 + 5) / 6 - 1), FRAC_ONE, FRAC_HALF);
        end
        send_color(FRAC_MAX, FRAC_ONE, FRAC_HALF);
        send_color(IN_W'(100000), FRAC_ONE, FRAC_HALF);
        send_color(IN_W'(21845), FRAC_MAX, FRAC_HALF);
        send_color(IN_W'(21845), FRAC_ONE, FRAC_MAX);
        send_color(IN_W'(43690), FRAC_HALF, IN_W'(90000));
        send_color(FRAC_MAX, FRAC_MAX, FRAC_MAX);
        send_color(IN_W'(54613), FRAC_ONE, '0);
        send_color(IN_W'(1), IN_W'(1), IN_W'(1));
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        repeat (count) begin
            send_color(random_hue(), random_fraction(), random_fraction());
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(350, 0, 0);
        test_random(300, 76, 0);
        test_random(300, 0, 76);
        test_random(300, 16, 16);
        i_valid = 1'b0;
        while (expected_rgb.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("hsl_to_rgb_converter test passed");
        end else begin
            $display("hsl_to_rgb_converter test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("hsl_to_rgb_converter test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/hsl2rgb_pkg.sv
design/hsl2rgb_to_byte.sv
design/hsl_to_rgb_converter.sv
design/hsl2rgb_checker.sv
tb/tb_top.sv
